FILE: design/sscr_pkg.sv
// ----------------------------------------------------------------------------
// sscr_pkg: shared types and constants
// Digit bundle type, command addresses and the seven-segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package sscr_pkg;

  typedef struct packed {
    logic [3:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  localparam logic [7:0] CMD_CONTROL   = 8'h48;
  localparam logic [7:0] CONTROL_RESET = 8'h51;
  localparam logic [6:0] DIGIT_CLAMP   = 7'd15;
  localparam logic [2:0] LAST_BEAT     = 3'd4;

  // Reciprocal constants for the digit split by 1000, 100 and 10.
  localparam logic [32:0] RECIP_1000 = 33'd67109;
  localparam int          SHIFT_1000 = 26;
  localparam logic [15:0] RECIP_100  = 16'd41;
  localparam int          SHIFT_100  = 12;
  localparam logic [13:0] RECIP_10   = 14'd103;
  localparam int          SHIFT_10   = 10;

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'h0: p = 8'h3F;
      4'h1: p = 8'h06;
      4'h2: p = 8'h5B;
      4'h3: p = 8'h4F;
      4'h4: p = 8'h66;
      4'h5: p = 8'h6D;
      4'h6: p = 8'h7D;
      4'h7: p = 8'h07;
      4'h8: p = 8'h7F;
      4'h9: p = 8'h6F;
      4'hA: p = 8'h77;
      4'hB: p = 8'h7C;
      4'hC: p = 8'h39;
      4'hD: p = 8'h5E;
      4'hE: p = 8'h79;
      4'hF: p = 8'h71;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] digit_reg(input logic [1:0] idx);
    logic [7:0] a;
    case (idx)
      2'd0: a = 8'h68;
      2'd1: a = 8'h6A;
      2'd2: a = 8'h6C;
      2'd3: a = 8'h6E;
      default: a = 8'h68;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/sscr_ifs.sv
// ----------------------------------------------------------------------------
// sscr_ifs: stream channel interfaces
// Valid/ready channels for count items and display commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface sscr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] count;

  modport source (output valid, output kind, output count, input ready);
  modport sink   (input valid, input kind, input count, output ready);
endinterface

interface sscr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] address_byte;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output address_byte, output data_byte, output last,
                  input ready);
  modport sink   (input valid, input address_byte, input data_byte, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: design/sscr_front.sv
// ----------------------------------------------------------------------------
// sscr_front: item intake and digit split
// Filters unchanged refreshes and splits the count into decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  sscr_in_if.sink             in_ch,
  output      logic           push,
  output      sscr_pkg::digits_t push_data,
  input  wire logic           full
);

  logic        adv;
  logic        take;
  logic [15:0] shown_r, shown_nxt;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [15:0] cnt1_r, cnt2_r;
  logic [6:0]  q2_r;
  logic [3:0]  thou3_r, thou4_r;
  logic [9:0]  rem3_r;
  logic [3:0]  hund4_r;
  logic [6:0]  rem4_r;
  sscr_pkg::digits_t dig5_r;

  logic [32:0] prod1;
  logic [16:0] qk2, rem2;
  logic [15:0] prod3;
  logic [3:0]  hund3;
  logic [9:0]  hk3, rem3b;
  logic [13:0] prod4;
  logic [3:0]  tens4;
  logic [6:0]  tk4, units4;

  assign adv         = !(v5_r && full);
  assign in_ch.ready = adv;
  assign take        = in_ch.valid && adv;
  assign push        = v5_r && !full;
  assign push_data   = dig5_r;

  always_comb begin
    shown_nxt = shown_r;
    if (take && !in_ch.kind) begin
      shown_nxt = in_ch.count;
    end
  end

  always_comb begin
    prod1  = {17'b0, cnt1_r} * sscr_pkg::RECIP_1000;
    qk2    = 17'(q2_r) * 17'd1000;
    rem2   = {1'b0, cnt2_r} - qk2;
    prod3  = 16'(rem3_r) * sscr_pkg::RECIP_100;
    hund3  = prod3[sscr_pkg::SHIFT_100 +: 4];
    hk3    = 10'(hund3) * 10'd100;
    rem3b  = rem3_r - hk3;
    prod4  = 14'(rem4_r) * sscr_pkg::RECIP_10;
    tens4  = prod4[sscr_pkg::SHIFT_10 +: 4];
    tk4    = 7'(tens4) * 7'd10;
    units4 = rem4_r - tk4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
    end else begin
      shown_r <= shown_nxt;
      if (adv) begin
        v1_r <= in_ch.valid && (in_ch.kind || (in_ch.count != shown_r));
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt1_r  <= in_ch.count;
      cnt2_r  <= cnt1_r;
      q2_r    <= prod1[sscr_pkg::SHIFT_1000 +: 7];
      thou3_r <= (q2_r > sscr_pkg::DIGIT_CLAMP) ? 4'hF : q2_r[3:0];
      rem3_r  <= rem2[9:0];
      thou4_r <= thou3_r;
      hund4_r <= hund3;
      rem4_r  <= rem3b[6:0];
      dig5_r.thou  <= thou4_r;
      dig5_r.hund  <= hund4_r;
      dig5_r.tens  <= tens4;
      dig5_r.units <= units4[3:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/sscr_queue.sv
// ----------------------------------------------------------------------------
// sscr_queue: digit bundle queue
// Small first-in first-out buffer between the intake and command sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sscr_pkg::digits_t push_data,
  output      logic              full,
  input  wire logic              pop,
  output      logic              nonempty,
  output      sscr_pkg::digits_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sscr_pkg::digits_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r, fill_nxt;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (fill_r == CW'(DEPTH));
  assign nonempty = (fill_r != '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/sscr_back.sv
// ----------------------------------------------------------------------------
// sscr_back: command sequencer
// Emits the control command and the four digit commands for each bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        control,
  input  wire logic              nonempty,
  input  wire sscr_pkg::digits_t pop_data,
  output      logic              pop,
  sscr_out_if.source             out_ch
);

  logic              busy_r, busy_nxt;
  logic [2:0]        beat_r, beat_nxt;
  sscr_pkg::digits_t dig_r;
  logic              valid_r, valid_nxt;
  logic [7:0]        addr_r, addr_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              last_r, last_nxt;
  logic              adv;
  logic [1:0]        sel;
  logic [3:0]        digit;

  assign adv                 = !valid_r || out_ch.ready;
  assign out_ch.valid        = valid_r;
  assign out_ch.address_byte = addr_r;
  assign out_ch.data_byte    = data_r;
  assign out_ch.last         = last_r;

  always_comb begin
    sel = 2'(beat_r - 3'd1);
    case (sel)
      2'd0: digit = dig_r.thou;
      2'd1: digit = dig_r.hund;
      2'd2: digit = dig_r.tens;
      2'd3: digit = dig_r.units;
      default: digit = dig_r.units;
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    beat_nxt  = beat_r;
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (adv) begin
      if (busy_r) begin
        valid_nxt = 1'b1;
        addr_nxt  = sscr_pkg::digit_reg(sel);
        data_nxt  = sscr_pkg::seg_pattern(digit);
        last_nxt  = (beat_r == sscr_pkg::LAST_BEAT);
        busy_nxt  = (beat_r != sscr_pkg::LAST_BEAT);
        beat_nxt  = beat_r + 3'd1;
      end else if (nonempty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        addr_nxt  = sscr_pkg::CMD_CONTROL;
        data_nxt  = control;
        last_nxt  = 1'b0;
        busy_nxt  = 1'b1;
        beat_nxt  = 3'd1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      beat_r  <= 3'd1;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    if (pop) begin
      dig_r <= pop_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/seven_segment_count_refresh.sv
// ----------------------------------------------------------------------------
// seven_segment_count_refresh: four-digit display command generator
// Items on in_ch carry a kind bit and a 16-bit count. A refresh item whose
// count equals the last refreshed count is dropped; any other item yields
// five transactions on out_ch: the control command 0x48 with the byte last
// written on cfg_wdata, then digit registers 0x68, 0x6A, 0x6C and 0x6E with
// the seven-segment patterns of the thousands, hundreds, tens and units.
// The last flag marks the fifth transaction. Only refresh items update the
// stored count.
// One command leaves per cycle while out_ch is ready, and the command
// sequencer starts each run as soon as the last one ends; the digit split
// takes a new item while earlier items are still in flight.
// A five-stage digit split feeds a queue of QUEUE_DEPTH runs; when out_ch
// stalls the queue fills and then in_ch.ready drops.
// Reset clears the stored count to zero, sets the control byte to 0x51 and
// empties the pipeline, the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_count_refresh #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sscr_in_if.sink         in_ch,
  sscr_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0]        control_r;
  logic              push, full, pop, nonempty;
  sscr_pkg::digits_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= sscr_pkg::CONTROL_RESET;
    end else if (cfg_we) begin
      control_r <= cfg_wdata;
    end
  end

  sscr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  sscr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_data  (pop_data)
  );

  sscr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .control  (control_r),
    .nonempty (nonempty),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: test/seven_segment_count_refresh_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_count_refresh_tb: self-checking testbench
// Sends refresh and init count items, predicts the five-command display runs
// with a local model of the digit split and the stored count, and checks every
// output transaction. Runs through several control byte values, random idle
// bursts on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module seven_segment_count_refresh_tb;

  localparam logic KIND_REFRESH = 1'b0;
  localparam logic KIND_INIT    = 1'b1;

  localparam int DIGITS          = 4;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 200;
  localparam int PHASE_ITEMS     = 70;
  localparam int PHASES          = 5;
  localparam int PRESSURE_PHASE  = 2;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 40;
  localparam int DIRECTED_COUNT  = 24;

  localparam logic [7:0] SEG_LUT [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };
  localparam logic [7:0] DIGIT_ADDR [DIGITS] = '{8'h68, 8'h6A, 8'h6C, 8'h6E};

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] count;
    logic        typed;
    logic        silent;
    logic [31:0] pats;
  } row_t;

  // Typed rows carry the four segment patterns, thousands first.
  localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{KIND_REFRESH, 16'd0,     1'b1, 1'b1, 32'h0},
    '{KIND_INIT,    16'd0,     1'b1, 1'b0, 32'h3F3F3F3F},
    '{KIND_REFRESH, 16'd0,     1'b1, 1'b1, 32'h0},
    '{KIND_REFRESH, 16'd65535, 1'b1, 1'b0, 32'h716D4F6D},
    '{KIND_REFRESH, 16'd65535, 1'b1, 1'b1, 32'h0},
    '{KIND_INIT,    16'd65535, 1'b1, 1'b0, 32'h716D4F6D},
    '{KIND_REFRESH, 16'd16000, 1'b1, 1'b0, 32'h713F3F3F},
    '{KIND_REFRESH, 16'd15999, 1'b1, 1'b0, 32'h716F6F6F},
    '{KIND_REFRESH, 16'd9999,  1'b1, 1'b0, 32'h6F6F6F6F},
    '{KIND_REFRESH, 16'd1,     1'b1, 1'b0, 32'h3F3F3F06},
    '{KIND_INIT,    16'd12345, 1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd1,     1'b1, 1'b1, 32'h0},
    '{KIND_REFRESH, 16'd0,     1'b1, 1'b0, 32'h3F3F3F3F},
    '{KIND_REFRESH, 16'd10,    1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd10,    1'b1, 1'b1, 32'h0},
    '{KIND_REFRESH, 16'd43690, 1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd21845, 1'b0, 1'b0, 32'h0},
    '{KIND_INIT,    16'd21845, 1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd10000, 1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd13579, 1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd2468,  1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd256,   1'b0, 1'b0, 32'h0},
    '{KIND_REFRESH, 16'd32768, 1'b0, 1'b0, 32'h0},
    '{KIND_INIT,    16'd0,     1'b1, 1'b0, 32'h3F3F3F3F}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  sscr_in_if  in_ch ();
  sscr_out_if out_ch ();

  logic [15:0] shown_count_model   = '0;
  logic [7:0]  control_byte_model  = sscr_pkg::CONTROL_RESET;
  cmd_t        expected_cmds [$];
  int          fail_count          = 0;
  int          cycle_count         = 0;
  bit          idle_on             = 1'b1;
  logic        out_hold            = 1'b0;

  seven_segment_count_refresh i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // Updates the stored count for refresh items and returns 1 when the item causes a run.
  function automatic bit advance_display(input logic kind, input logic [15:0] count,
                                         output logic [31:0] pats);
    int unsigned digit [DIGITS];
    pats = '0;
    if (kind == KIND_REFRESH) begin
      if (count == shown_count_model) return 1'b0;
      shown_count_model = count;
    end
    digit[0] = count / 1000;
    digit[1] = (count / 100) % 10;
    digit[2] = (count / 10) % 10;
    digit[3] = count % 10;
    if (digit[0] > 15) digit[0] = 15;
    for (int i = 0; i < DIGITS; i++) begin
      pats[31 - 8 * i -: 8] = SEG_LUT[digit[i]];
    end
    return 1'b1;
  endfunction

  function automatic void push_run(input logic [31:0] pats);
    expected_cmds.push_back('{sscr_pkg::CMD_CONTROL, control_byte_model, 1'b0});
    for (int i = 0; i < DIGITS; i++) begin
      expected_cmds.push_back('{DIGIT_ADDR[i], pats[31 - 8 * i -: 8], i == DIGITS - 1});
    end
  endfunction

  function automatic void expect_row(input row_t r);
    logic [31:0] pats;
    bit          emits;
    emits = advance_display(r.kind, r.count, pats);
    if (r.typed) begin
      if (!r.silent) push_run(r.pats);
    end else if (emits) begin
      push_run(pats);
    end
  endfunction

  task automatic check_command();
    cmd_t want;
    if (expected_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected command addr %h data %h last %b",
                                out_ch.address_byte, out_ch.data_byte, out_ch.last));
      return;
    end
    want = expected_cmds.pop_front();
    if (out_ch.address_byte !== want.addr || out_ch.data_byte !== want.data ||
        out_ch.last !== want.last) begin
      report_mismatch($sformatf("got addr %h data %h last %b, want addr %h data %h last %b",
                                out_ch.address_byte, out_ch.data_byte, out_ch.last,
                                want.addr, want.data, want.last));
    end
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 99));
      1: return 16'($urandom_range(0, 9999));
      2: return 16'($urandom_range(15990, 16010));
      3: return 16'($urandom_range(16000, 65535));
      4: return shown_count_model ^ (16'd1 << $urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_count(input row_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= r.kind;
    in_ch.count <= r.count;
    do @(posedge clk); while (!in_ch.ready);
    expect_row(r);
  endtask

  task automatic run_random(input int n);
    row_t r;
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.kind  = ($urandom_range(0, 4) == 0) ? KIND_INIT : KIND_REFRESH;
      r.count = ($urandom_range(0, 3) == 0) ? shown_count_model : pick_count();
      send_count(r);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_control(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    control_byte_model = value;
  endtask

  task automatic hold_output(input int cycles);
    out_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    out_hold <= 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_command();
      if (out_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] phase_ctrl [PHASES];
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_REFRESH;
    in_ch.count <= '0;
    phase_ctrl[0] = 8'h00;
    phase_ctrl[1] = 8'hFF;
    phase_ctrl[2] = 8'($urandom());
    phase_ctrl[3] = 8'($urandom());
    phase_ctrl[4] = 8'($urandom());
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_count(DIRECTED_ROWS[i]);
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_control(phase_ctrl[p]);
      idle_on = (p != PHASES - 1);
      if (p == PRESSURE_PHASE) begin
        fork
          hold_output(HOLD_CYCLES);
        join_none
      end
      run_random(PHASE_ITEMS);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
